[sv/pgl_pkg.sv]
`timescale 1ns / 1ps

package pgl_pkg;

   // Table geometry.
   localparam int VALUE_BITS  = 16;
   localparam int PRIME_SLOTS = 8192;

   localparam int unsigned TABLE_SIZE = 32'd1 << VALUE_BITS;

   // The sweep pointer must be able to hold TABLE_SIZE itself.
   localparam int ADDR_BITS  = VALUE_BITS + 1;
   localparam int SQ_BITS    = 2 * ADDR_BITS;
   localparam int IDX_BITS   = $clog2(PRIME_SLOTS);
   localparam int COUNT_BITS = IDX_BITS + 1;
   localparam int SUM_BITS   = (ADDR_BITS > COUNT_BITS + 1) ? ADDR_BITS : COUNT_BITS + 1;

   // Transaction field widths.
   localparam int QUERY_BITS  = 16;
   localparam int GAP_BITS    = 8;
   localparam int STATUS_BITS = 2;
   localparam int CMP_BITS    = (VALUE_BITS > QUERY_BITS) ? VALUE_BITS : QUERY_BITS;
   localparam int GAP_MAX     = 255;

   localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(TABLE_SIZE - 32'd1);

   // Action codes.
   localparam logic ACTION_BUILD = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   // Status codes.
   localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_NOT_BUILT = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_NO_ABOVE  = 2'd2;

   typedef struct packed {
      logic                  start;
      logic                  action;
      logic [QUERY_BITS-1:0] query_value;
   } eng_cmd_type;

   typedef struct packed {
      logic                   idle;
      logic                   done;
      logic [GAP_BITS-1:0]    gap;
      logic [STATUS_BITS-1:0] status;
   } eng_stat_type;

endpackage

[sv/pgl_engine.sv]
`timescale 1ns / 1ps

module pgl_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  pgl_pkg::eng_cmd_type  cmd,
   input  logic                  result_taken,
   output pgl_pkg::eng_stat_type stat
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_CLEAR = 4'd1;
   localparam logic [3:0] S_SQ    = 4'd2;
   localparam logic [3:0] S_SQCHK = 4'd3;
   localparam logic [3:0] S_ITEST = 4'd4;
   localparam logic [3:0] S_MARK  = 4'd5;
   localparam logic [3:0] S_LIST  = 4'd6;
   localparam logic [3:0] S_LTEST = 4'd7;
   localparam logic [3:0] S_QCOMP = 4'd8;
   localparam logic [3:0] S_QMID  = 4'd9;
   localparam logic [3:0] S_QCMP  = 4'd10;
   localparam logic [3:0] S_QHI   = 4'd11;
   localparam logic [3:0] S_QLO   = 4'd12;
   localparam logic [3:0] S_DONE  = 4'd13;

   // Composite bitmap and ascending prime list.
   logic                           comp_map_mem [pgl_pkg::TABLE_SIZE];
   logic [pgl_pkg::VALUE_BITS-1:0] prime_mem    [pgl_pkg::PRIME_SLOTS];

   logic [3:0]                      state_ff, state_in;
   logic [pgl_pkg::ADDR_BITS-1:0]   i_ff, i_in;
   logic [pgl_pkg::ADDR_BITS-1:0]   j_ff, j_in;
   logic [pgl_pkg::SQ_BITS-1:0]     sq_ff, sq_in;
   logic [pgl_pkg::COUNT_BITS-1:0]  lo_ff, lo_in;
   logic [pgl_pkg::COUNT_BITS-1:0]  hi_ff, hi_in;
   logic [pgl_pkg::COUNT_BITS-1:0]  mid_ff, mid_in;
   logic [pgl_pkg::COUNT_BITS-1:0]  count_ff, count_in;
   logic                            ready_ff, ready_in;
   logic [pgl_pkg::QUERY_BITS-1:0]  value_ff, value_in;
   logic [pgl_pkg::VALUE_BITS-1:0]  upper_ff, upper_in;
   logic [pgl_pkg::GAP_BITS-1:0]    gap_ff, gap_in;
   logic [pgl_pkg::STATUS_BITS-1:0] status_ff, status_in;

   logic                           comp_rd_ff;
   logic [pgl_pkg::VALUE_BITS-1:0] prime_rd_ff;

   logic                           comp_we;
   logic [pgl_pkg::VALUE_BITS-1:0] comp_waddr;
   logic                           comp_wdata;
   logic [pgl_pkg::VALUE_BITS-1:0] comp_raddr;
   logic                           prime_we;
   logic [pgl_pkg::IDX_BITS-1:0]   prime_waddr;
   logic [pgl_pkg::VALUE_BITS-1:0] prime_wdata;
   logic [pgl_pkg::IDX_BITS-1:0]   prime_raddr;

   // The adder that the sweeps, the sieve marking and the search steps share.
   logic [pgl_pkg::SUM_BITS-1:0]   add_a, add_b, add_sum;
   logic [pgl_pkg::SUM_BITS-1:0]   mid_wide;
   logic [pgl_pkg::COUNT_BITS-1:0] lo_m1;
   logic [pgl_pkg::VALUE_BITS-1:0] diff;

   assign add_sum  = add_a + add_b;
   assign mid_wide = add_sum >> 1;
   assign lo_m1    = lo_ff - pgl_pkg::COUNT_BITS'(1);
   assign diff     = upper_ff - prime_rd_ff;

   always_comb begin
      state_in    = state_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      sq_in       = sq_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      mid_in      = mid_ff;
      count_in    = count_ff;
      ready_in    = ready_ff;
      value_in    = value_ff;
      upper_in    = upper_ff;
      gap_in      = gap_ff;
      status_in   = status_ff;
      comp_we     = 1'b0;
      comp_waddr  = j_ff[pgl_pkg::VALUE_BITS-1:0];
      comp_wdata  = 1'b0;
      comp_raddr  = i_ff[pgl_pkg::VALUE_BITS-1:0];
      prime_we    = 1'b0;
      prime_waddr = count_ff[pgl_pkg::IDX_BITS-1:0];
      prime_wdata = j_ff[pgl_pkg::VALUE_BITS-1:0];
      prime_raddr = lo_ff[pgl_pkg::IDX_BITS-1:0];
      add_a       = '0;
      add_b       = '0;

      case (state_ff)
         S_IDLE: begin
            if (cmd.start) begin
               value_in = cmd.query_value;
               gap_in   = '0;
               if (cmd.action == pgl_pkg::ACTION_BUILD) begin
                  j_in     = '0;
                  count_in = '0;
                  state_in = S_CLEAR;
               end else if (!ready_ff) begin
                  status_in = pgl_pkg::STATUS_NOT_BUILT;
                  state_in  = S_DONE;
               end else if (32'(cmd.query_value) >= pgl_pkg::TABLE_SIZE) begin
                  status_in = pgl_pkg::STATUS_NO_ABOVE;
                  state_in  = S_DONE;
               end else begin
                  comp_raddr = pgl_pkg::VALUE_BITS'(cmd.query_value);
                  state_in   = S_QCOMP;
               end
            end
         end

         S_CLEAR: begin
            comp_we = 1'b1;
            add_a   = pgl_pkg::SUM_BITS'(j_ff);
            add_b   = pgl_pkg::SUM_BITS'(1);
            if (j_ff == pgl_pkg::LAST_ADDR) begin
               i_in     = pgl_pkg::ADDR_BITS'(2);
               state_in = S_SQ;
            end else begin
               j_in = pgl_pkg::ADDR_BITS'(add_sum);
            end
         end

         S_SQ: begin
            sq_in    = pgl_pkg::SQ_BITS'(i_ff) * pgl_pkg::SQ_BITS'(i_ff);
            state_in = S_SQCHK;
         end

         S_SQCHK: begin
            if (sq_ff >= pgl_pkg::SQ_BITS'(pgl_pkg::TABLE_SIZE)) begin
               j_in     = pgl_pkg::ADDR_BITS'(2);
               state_in = S_LIST;
            end else begin
               state_in = S_ITEST;
            end
         end

         S_ITEST: begin
            if (comp_rd_ff) begin
               add_a    = pgl_pkg::SUM_BITS'(i_ff);
               add_b    = pgl_pkg::SUM_BITS'(1);
               i_in     = pgl_pkg::ADDR_BITS'(add_sum);
               state_in = S_SQ;
            end else begin
               j_in     = pgl_pkg::ADDR_BITS'(sq_ff);
               state_in = S_MARK;
            end
         end

         S_MARK: begin
            if (j_ff < pgl_pkg::ADDR_BITS'(pgl_pkg::TABLE_SIZE)) begin
               comp_we    = 1'b1;
               comp_wdata = 1'b1;
               add_a      = pgl_pkg::SUM_BITS'(j_ff);
               add_b      = pgl_pkg::SUM_BITS'(i_ff);
               j_in       = pgl_pkg::ADDR_BITS'(add_sum);
            end else begin
               add_a    = pgl_pkg::SUM_BITS'(i_ff);
               add_b    = pgl_pkg::SUM_BITS'(1);
               i_in     = pgl_pkg::ADDR_BITS'(add_sum);
               state_in = S_SQ;
            end
         end

         S_LIST: begin
            comp_raddr = j_ff[pgl_pkg::VALUE_BITS-1:0];
            state_in   = S_LTEST;
         end

         S_LTEST: begin
            // Primes beyond the list capacity are dropped.
            if (!comp_rd_ff && (count_ff < pgl_pkg::COUNT_BITS'(pgl_pkg::PRIME_SLOTS))) begin
               prime_we = 1'b1;
               count_in = count_ff + pgl_pkg::COUNT_BITS'(1);
            end
            add_a = pgl_pkg::SUM_BITS'(j_ff);
            add_b = pgl_pkg::SUM_BITS'(1);
            if (j_ff == pgl_pkg::LAST_ADDR) begin
               ready_in  = 1'b1;
               status_in = pgl_pkg::STATUS_OK;
               state_in  = S_DONE;
            end else begin
               j_in     = pgl_pkg::ADDR_BITS'(add_sum);
               state_in = S_LIST;
            end
         end

         S_QCOMP: begin
            if (!comp_rd_ff) begin
               status_in = pgl_pkg::STATUS_OK;
               state_in  = S_DONE;
            end else begin
               lo_in    = '0;
               hi_in    = count_ff;
               state_in = S_QMID;
            end
         end

         S_QMID: begin
            if (lo_ff < hi_ff) begin
               add_a       = pgl_pkg::SUM_BITS'(lo_ff);
               add_b       = pgl_pkg::SUM_BITS'(hi_ff);
               mid_in      = pgl_pkg::COUNT_BITS'(mid_wide);
               prime_raddr = mid_wide[pgl_pkg::IDX_BITS-1:0];
               state_in    = S_QCMP;
            end else if ((lo_ff == '0) || (lo_ff >= count_ff)) begin
               status_in = pgl_pkg::STATUS_NO_ABOVE;
               state_in  = S_DONE;
            end else begin
               state_in = S_QHI;
            end
         end

         S_QCMP: begin
            if (pgl_pkg::CMP_BITS'(prime_rd_ff) > pgl_pkg::CMP_BITS'(value_ff)) begin
               hi_in = mid_ff;
            end else begin
               add_a = pgl_pkg::SUM_BITS'(mid_ff);
               add_b = pgl_pkg::SUM_BITS'(1);
               lo_in = pgl_pkg::COUNT_BITS'(add_sum);
            end
            state_in = S_QMID;
         end

         S_QHI: begin
            upper_in    = prime_rd_ff;
            prime_raddr = lo_m1[pgl_pkg::IDX_BITS-1:0];
            state_in    = S_QLO;
         end

         S_QLO: begin
            if (32'(diff) > 32'(pgl_pkg::GAP_MAX)) begin
               gap_in = pgl_pkg::GAP_BITS'(pgl_pkg::GAP_MAX);
            end else begin
               gap_in = pgl_pkg::GAP_BITS'(diff);
            end
            status_in = pgl_pkg::STATUS_OK;
            state_in  = S_DONE;
         end

         S_DONE: begin
            if (result_taken) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ready_ff <= ready_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff      <= i_in;
      j_ff      <= j_in;
      sq_ff     <= sq_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      value_ff  <= value_in;
      upper_ff  <= upper_in;
      gap_ff    <= gap_in;
      status_ff <= status_in;
   end

   always_ff @(posedge clock) begin
      if (comp_we) begin
         comp_map_mem[comp_waddr] <= comp_wdata;
      end
      comp_rd_ff <= comp_map_mem[comp_raddr];
   end

   always_ff @(posedge clock) begin
      if (prime_we) begin
         prime_mem[prime_waddr] <= prime_wdata;
      end
      prime_rd_ff <= prime_mem[prime_raddr];
   end

   assign stat.idle   = (state_ff == S_IDLE);
   assign stat.done   = (state_ff == S_DONE);
   assign stat.gap    = gap_ff;
   assign stat.status = status_ff;

endmodule

[sv/prime_gap_lookup_core.sv]
`timescale 1ns / 1ps

// Prime gap look-up. A build transaction (req_tuser = 0) sieves every value
// below 2^16 into a composite bitmap and an ascending prime list; it clears
// the bitmap entry by entry, marks each composite, and then scans the bitmap
// entry by entry into the prime list. A query transaction (req_tuser = 1)
// answers the distance between the primes just below and just above
// req_tdata, with gap 0 for a prime, 0 or 1. For a composite value the
// binary search over the stored primes reads the prime list memory once per
// search step, each read depending on the one before.
// One transaction is worked on at a time; req_tready is low until the engine
// is free, while a finished result may still wait in the output register.
// The status in rsp_tuser is 1 when no build was done yet and 2 when no
// stored prime lies above the value; the gap is then 0.
module prime_gap_lookup_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [15:0] query_value
   input  logic [0:0]  req_tuser,  // [0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // [7:0] gap
   output logic [1:0]  rsp_tuser   // [1:0] status
);

   pgl_pkg::eng_cmd_type  eng_cmd;
   pgl_pkg::eng_stat_type eng_stat;
   logic                  result_taken;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [pgl_pkg::GAP_BITS-1:0]    rsp_gap_ff;
   logic [pgl_pkg::STATUS_BITS-1:0] rsp_status_ff;

   assign req_tready = eng_stat.idle;

   assign eng_cmd.start       = req_tvalid && req_tready;
   assign eng_cmd.action      = req_tuser[0];
   assign eng_cmd.query_value = req_tdata;

   // The engine hands over its result once the output register is free.
   assign result_taken = eng_stat.done && (!rsp_valid_ff || rsp_tready);

   pgl_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .cmd          (eng_cmd),
      .result_taken (result_taken),
      .stat         (eng_stat)
   );

   always_comb begin
      if (result_taken) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result_taken) begin
         rsp_gap_ff    <= eng_stat.gap;
         rsp_status_ff <= eng_stat.status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_gap_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

[sv/pgl_checker.sv]
`timescale 1ns / 1ps

module pgl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [15:0] req_tdata,
   input logic [0:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // A stalled result stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn while stalled");

   // A stalled result keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result payload changed while stalled");

   // Every accepted transaction leaves the engine busy in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted on back-to-back cycles");

   // Only the three defined status codes appear.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == pgl_pkg::STATUS_OK)
                     || (rsp_tuser == pgl_pkg::STATUS_NOT_BUILT)
                     || (rsp_tuser == pgl_pkg::STATUS_NO_ABOVE))
      else $error("undefined status code");

   // An error result carries no gap.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != pgl_pkg::STATUS_OK) |-> rsp_tdata == 8'd0)
      else $error("nonzero gap with error status");

endmodule

bind prime_gap_lookup_core pgl_checker u_pgl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
